>>> hdl/triangle_tangent_basis_assert.svh
// Assertion macros for the triangle tangent basis block.
// Used by modules that have clk and rst_n in scope.
`ifndef TRIANGLE_TANGENT_BASIS_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_ASSERT_SVH
`ifndef SYNTH
`define TTB_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("triangle_tangent_basis assertion failed");
`define TTB_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("triangle_tangent_basis assertion failed");
`else
`define TTB_ASSERT_NOW(lbl, cond, prop)
`define TTB_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

>>> hdl/ttb_pkg.sv
// Shared types, widths and helpers for the triangle tangent basis block.
// No dependencies.
package ttb_pkg;

    localparam int IDX_BITS_DEFAULT = 16;
    localparam int INDEX_W = 16;
    localparam int POS_W   = 24;
    localparam int TEX_W   = 16;
    localparam int DP_W    = 25;
    localparam int DT_W    = 17;
    localparam int PROD_W  = 42;
    localparam int ACC_W   = 43;
    localparam int DET_W   = 35;
    localparam int NUM_W   = 60;
    localparam int DEN_W   = 36;
    localparam int OUT_W   = 32;

    typedef struct packed {
        logic [INDEX_W-1:0]        idx0;
        logic [INDEX_W-1:0]        idx1;
        logic [INDEX_W-1:0]        idx2;
        logic [2:0][DP_W-1:0]      dp1;
        logic [2:0][DP_W-1:0]      dp2;
        logic [DT_W-1:0]           du1;
        logic [DT_W-1:0]           dv1;
        logic [DT_W-1:0]           du2;
        logic [DT_W-1:0]           dv2;
    } tri_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [OUT_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_A,
        B_MUL_B,
        B_SUB,
        B_PREP,
        B_DIV,
        B_EMIT
    } back_state_t;

    function automatic logic [OUT_W-1:0] sat_q(input logic neg, input logic ovf,
                                               input logic [OUT_W-1:0] q);
        logic [OUT_W-1:0] r;
        if (neg)
        begin
            if (ovf || q[OUT_W-1])
                r = {1'b1, {(OUT_W-1){1'b0}}};
            else
                r = ~q + 1'b1;
        end
        else
        begin
            if (ovf || q[OUT_W-1])
                r = {1'b0, {(OUT_W-1){1'b1}}};
            else
                r = q;
        end
        return r;
    endfunction

endpackage

>>> hdl/ttb_front.sv
// Front part: accepts corners, holds the first two, builds the triangle record.
// Depends on ttb_pkg.
module ttb_front #(
    parameter int INDEX_BITS = ttb_pkg::IDX_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttb_pkg::INDEX_W-1:0]   vertex_index,
    input  logic signed [ttb_pkg::POS_W-1:0] pos_x,
    input  logic signed [ttb_pkg::POS_W-1:0] pos_y,
    input  logic signed [ttb_pkg::POS_W-1:0] pos_z,
    input  logic signed [ttb_pkg::TEX_W-1:0] tex_u,
    input  logic signed [ttb_pkg::TEX_W-1:0] tex_v,
    output logic                          push,
    output ttb_pkg::tri_t                 push_data,
    input  logic                          full
);
    localparam int IDX_W = (INDEX_BITS < ttb_pkg::INDEX_W) ? INDEX_BITS : ttb_pkg::INDEX_W;

    logic [1:0]                                count_reg;
    logic [1:0]                                count_next;
    logic [1:0][IDX_W-1:0]                     idx_reg;
    logic [1:0][2:0][ttb_pkg::POS_W-1:0]       pos_reg;
    logic [1:0][1:0][ttb_pkg::TEX_W-1:0]       tex_reg;
    logic                                      take;
    logic [2:0][ttb_pkg::POS_W-1:0]            pos_in;

    assign pos_in   = {pos_z, pos_y, pos_x};
    assign in_ready = (count_reg != 2'd2) || !full;
    assign take     = in_valid && in_ready;
    assign push     = take && (count_reg == 2'd2);

    always_comb
    begin
        count_next = count_reg;
        if (take)
            count_next = (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && (count_reg != 2'd2))
        begin
            idx_reg[count_reg[0]]    <= vertex_index[IDX_W-1:0];
            pos_reg[count_reg[0]]    <= pos_in;
            tex_reg[count_reg[0]][0] <= tex_u;
            tex_reg[count_reg[0]][1] <= tex_v;
        end
    end

    always_comb
    begin
        push_data.idx0 = ttb_pkg::INDEX_W'(idx_reg[0]);
        push_data.idx1 = ttb_pkg::INDEX_W'(idx_reg[1]);
        push_data.idx2 = ttb_pkg::INDEX_W'(vertex_index[IDX_W-1:0]);
        for (int c = 0; c < 3; c++)
        begin
            push_data.dp1[c] = {pos_reg[1][c][ttb_pkg::POS_W-1], pos_reg[1][c]}
                             - {pos_reg[0][c][ttb_pkg::POS_W-1], pos_reg[0][c]};
            push_data.dp2[c] = {pos_in[c][ttb_pkg::POS_W-1], pos_in[c]}
                             - {pos_reg[0][c][ttb_pkg::POS_W-1], pos_reg[0][c]};
        end
        push_data.du1 = {tex_reg[1][0][ttb_pkg::TEX_W-1], tex_reg[1][0]}
                      - {tex_reg[0][0][ttb_pkg::TEX_W-1], tex_reg[0][0]};
        push_data.dv1 = {tex_reg[1][1][ttb_pkg::TEX_W-1], tex_reg[1][1]}
                      - {tex_reg[0][1][ttb_pkg::TEX_W-1], tex_reg[0][1]};
        push_data.du2 = {tex_u[ttb_pkg::TEX_W-1], tex_u}
                      - {tex_reg[0][0][ttb_pkg::TEX_W-1], tex_reg[0][0]};
        push_data.dv2 = {tex_v[ttb_pkg::TEX_W-1], tex_v}
                      - {tex_reg[0][1][ttb_pkg::TEX_W-1], tex_reg[0][1]};
    end

endmodule

>>> hdl/ttb_queue.sv
// Two-entry queue of triangle records between front and back.
// Depends on nothing but its WIDTH parameter.
module ttb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_reg;
    logic             rd_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

endmodule

>>> hdl/ttb_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detect.
// Depends on ttb_pkg.
module ttb_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ttb_pkg::div_req_t req,
    output ttb_pkg::div_rsp_t rsp
);
    localparam int HI_W = ttb_pkg::NUM_W - ttb_pkg::OUT_W;

    logic [ttb_pkg::DEN_W-1:0] rem_reg;
    logic [ttb_pkg::DEN_W-1:0] den_reg;
    logic [ttb_pkg::OUT_W-1:0] quo_reg;
    logic                      ovf_reg;
    logic [4:0]                cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [ttb_pkg::DEN_W:0]   trial;
    logic                      ge;

    assign trial = {rem_reg, quo_reg[ttb_pkg::OUT_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 5'd0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= ttb_pkg::DEN_W'(req.num[ttb_pkg::NUM_W-1:ttb_pkg::OUT_W]);
            quo_reg <= req.num[ttb_pkg::OUT_W-1:0];
            den_reg <= req.den;
            ovf_reg <= ttb_pkg::DEN_W'(req.num[ttb_pkg::NUM_W-1:ttb_pkg::NUM_W-HI_W])
                       >= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? ttb_pkg::DEN_W'(trial - {1'b0, den_reg})
                          : trial[ttb_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[ttb_pkg::OUT_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.ovf  = ovf_reg;
    assign rsp.quot = quo_reg;

endmodule

>>> hdl/ttb_back.sv
// Back part: determinant, six numerators and quotients, then three results.
// Depends on ttb_pkg, ttb_div and triangle_tangent_basis_assert.svh.
`include "triangle_tangent_basis_assert.svh"
module ttb_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               empty,
    input  ttb_pkg::tri_t                      tri_in,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [ttb_pkg::INDEX_W-1:0]        corner_index,
    output logic signed [ttb_pkg::OUT_W-1:0]   tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]   tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]   tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0]   bitangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0]   bitangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0]   bitangent_z,
    output logic                               degenerate,
    output logic                               last_of_triangle
);
    ttb_pkg::back_state_t              state_reg;
    ttb_pkg::back_state_t              state_next;
    logic [2:0]                        j_reg;
    logic [1:0]                        slot_reg;
    logic signed [ttb_pkg::PROD_W-1:0] prod_reg;
    logic signed [ttb_pkg::ACC_W-1:0]  acc_reg;
    logic signed [ttb_pkg::DET_W-1:0]  det_reg;
    logic                              degen_reg;
    logic                              neg_reg;
    logic [5:0][ttb_pkg::OUT_W-1:0]    res_reg;
    logic signed [ttb_pkg::DP_W-1:0]   ma;
    logic signed [ttb_pkg::DT_W-1:0]   mb;
    logic signed [ttb_pkg::PROD_W-1:0] prod;
    logic [ttb_pkg::DP_W-1:0]          dp1c;
    logic [ttb_pkg::DP_W-1:0]          dp2c;
    logic [ttb_pkg::ACC_W-1:0]         acc_abs;
    logic [ttb_pkg::DET_W-1:0]         det_abs;
    logic                              last_step;
    logic                              advance;
    ttb_pkg::div_req_t                 req;
    ttb_pkg::div_rsp_t                 rsp;

    ttb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        case (j_reg)
            3'd1, 3'd4: begin dp1c = tri_in.dp1[0]; dp2c = tri_in.dp2[0]; end
            3'd2, 3'd5: begin dp1c = tri_in.dp1[1]; dp2c = tri_in.dp2[1]; end
            default:    begin dp1c = tri_in.dp1[2]; dp2c = tri_in.dp2[2]; end
        endcase
    end

    always_comb
    begin
        logic first;
        first = (state_reg == ttb_pkg::B_MUL_A);
        if (j_reg == 3'd0)
        begin
            ma = first ? $signed({{(ttb_pkg::DP_W-ttb_pkg::DT_W){tri_in.du1[ttb_pkg::DT_W-1]}},
                                  tri_in.du1})
                       : $signed({{(ttb_pkg::DP_W-ttb_pkg::DT_W){tri_in.dv1[ttb_pkg::DT_W-1]}},
                                  tri_in.dv1});
            mb = first ? $signed(tri_in.dv2) : $signed(tri_in.du2);
        end
        else if (j_reg <= 3'd3)
        begin
            ma = first ? $signed(dp1c) : $signed(dp2c);
            mb = first ? $signed(tri_in.dv2) : $signed(tri_in.dv1);
        end
        else
        begin
            ma = first ? $signed(dp2c) : $signed(dp1c);
            mb = first ? $signed(tri_in.du1) : $signed(tri_in.du2);
        end
    end

    assign prod      = ma * mb;
    assign acc_abs   = acc_reg[ttb_pkg::ACC_W-1] ? ttb_pkg::ACC_W'(-acc_reg) : acc_reg;
    assign det_abs   = det_reg[ttb_pkg::DET_W-1] ? ttb_pkg::DET_W'(-det_reg) : det_reg;
    assign last_step = (j_reg == 3'd6);

    always_comb
    begin
        state_next = state_reg;
        advance    = 1'b0;
        pop        = 1'b0;
        req.start  = 1'b0;
        req.num    = ttb_pkg::NUM_W'({acc_abs[ttb_pkg::PROD_W-1:0], 17'd0})
                   + ttb_pkg::NUM_W'(det_abs);
        req.den    = {det_abs, 1'b0};
        unique case (state_reg)
            ttb_pkg::B_IDLE:
            begin
                if (!empty)
                    state_next = ttb_pkg::B_MUL_A;
            end
            ttb_pkg::B_MUL_A: state_next = ttb_pkg::B_MUL_B;
            ttb_pkg::B_MUL_B: state_next = ttb_pkg::B_SUB;
            ttb_pkg::B_SUB:   state_next = ttb_pkg::B_PREP;
            ttb_pkg::B_PREP:
            begin
                if (j_reg == 3'd0)
                    state_next = ttb_pkg::B_MUL_A;
                else if (degen_reg)
                    advance = 1'b1;
                else
                begin
                    req.start  = 1'b1;
                    state_next = ttb_pkg::B_DIV;
                end
            end
            ttb_pkg::B_DIV:
            begin
                if (rsp.done)
                    advance = 1'b1;
            end
            ttb_pkg::B_EMIT:
            begin
                if (out_ready && (slot_reg == 2'd2))
                begin
                    pop        = 1'b1;
                    state_next = ttb_pkg::B_IDLE;
                end
            end
            default: state_next = ttb_pkg::B_IDLE;
        endcase
        if (advance)
            state_next = last_step ? ttb_pkg::B_EMIT : ttb_pkg::B_MUL_A;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::B_IDLE;
            j_reg     <= 3'd0;
            slot_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ttb_pkg::B_IDLE)
                j_reg <= 3'd0;
            else if ((state_reg == ttb_pkg::B_PREP && j_reg == 3'd0) || (advance && !last_step))
                j_reg <= j_reg + 3'd1;
            if (state_reg != ttb_pkg::B_EMIT)
                slot_reg <= 2'd0;
            else if (out_ready)
                slot_reg <= slot_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ttb_pkg::B_MUL_A: prod_reg <= prod;
            ttb_pkg::B_MUL_B:
            begin
                acc_reg  <= {prod_reg[ttb_pkg::PROD_W-1], prod_reg};
                prod_reg <= prod;
            end
            ttb_pkg::B_SUB:   acc_reg <= acc_reg - {prod_reg[ttb_pkg::PROD_W-1], prod_reg};
            ttb_pkg::B_PREP:
            begin
                if (j_reg == 3'd0)
                begin
                    det_reg   <= acc_reg[ttb_pkg::DET_W-1:0];
                    degen_reg <= (acc_reg == '0);
                end
                else if (degen_reg)
                    res_reg[j_reg - 3'd1] <= '0;
                neg_reg <= acc_reg[ttb_pkg::ACC_W-1] ^ det_reg[ttb_pkg::DET_W-1];
            end
            ttb_pkg::B_DIV:
            begin
                if (rsp.done)
                    res_reg[j_reg - 3'd1] <= ttb_pkg::sat_q(neg_reg, rsp.ovf, rsp.quot);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        case (slot_reg)
            2'd0:    corner_index = tri_in.idx0;
            2'd1:    corner_index = tri_in.idx1;
            default: corner_index = tri_in.idx2;
        endcase
    end

    assign out_valid        = (state_reg == ttb_pkg::B_EMIT);
    assign tangent_x        = res_reg[0];
    assign tangent_y        = res_reg[1];
    assign tangent_z        = res_reg[2];
    assign bitangent_x      = res_reg[3];
    assign bitangent_y      = res_reg[4];
    assign bitangent_z      = res_reg[5];
    assign degenerate       = degen_reg;
    assign last_of_triangle = (slot_reg == 2'd2);

    `TTB_ASSERT_NOW(a_degen_zero, out_valid && degenerate, tangent_x == '0 && bitangent_y == '0)
    `TTB_ASSERT_NOW(a_pop_on_last, pop, out_valid && out_ready && last_of_triangle)
    `TTB_ASSERT_NOW(a_div_only_in_div, rsp.done, state_reg == ttb_pkg::B_DIV)
    `TTB_ASSERT_NOW(a_emit_has_tri, out_valid, !empty)

endmodule

>>> hdl/triangle_tangent_basis.sv
// Top level of the triangle tangent basis block: front, queue and back.
// Depends on ttb_pkg, ttb_front, ttb_queue and ttb_back.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready   | vertex_index, pos_x/y/z, tex_u/v
//   out     | out_valid / out_ready | corner_index, tangent_*, bitangent_*, flags
//
// The front takes one corner per cycle; the third corner pushes a record to a
// two-entry queue and stalls only when that queue is full.
// Before its results the back leaves idle, forms the determinant with two
// multiplies, a subtract and a prepare step, then per component does two multiplies,
// a subtract, a prepare step and a division; a degenerate triangle skips the divider.
// Three results follow, one per cycle while out_ready is high; reset clears
// corner count, queue and back state, with no clearing pass.
module triangle_tangent_basis #(
    parameter int INDEX_BITS = ttb_pkg::IDX_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ttb_pkg::INDEX_W-1:0]      vertex_index,
    input  logic signed [ttb_pkg::POS_W-1:0] pos_x,
    input  logic signed [ttb_pkg::POS_W-1:0] pos_y,
    input  logic signed [ttb_pkg::POS_W-1:0] pos_z,
    input  logic signed [ttb_pkg::TEX_W-1:0] tex_u,
    input  logic signed [ttb_pkg::TEX_W-1:0] tex_v,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ttb_pkg::INDEX_W-1:0]      corner_index,
    output logic signed [ttb_pkg::OUT_W-1:0] tangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0] tangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0] tangent_z,
    output logic signed [ttb_pkg::OUT_W-1:0] bitangent_x,
    output logic signed [ttb_pkg::OUT_W-1:0] bitangent_y,
    output logic signed [ttb_pkg::OUT_W-1:0] bitangent_z,
    output logic                             degenerate,
    output logic                             last_of_triangle
);
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;
    ttb_pkg::tri_t push_data;
    ttb_pkg::tri_t head;

    ttb_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .push         (push),
        .push_data    (push_data),
        .full         (full)
    );

    ttb_queue #(
        .WIDTH ($bits(ttb_pkg::tri_t))
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_data),
        .full  (full),
        .pop   (pop),
        .dout  (head),
        .empty (empty)
    );

    ttb_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .empty            (empty),
        .tri_in           (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .corner_index     (corner_index),
        .tangent_x        (tangent_x),
        .tangent_y        (tangent_y),
        .tangent_z        (tangent_z),
        .bitangent_x      (bitangent_x),
        .bitangent_y      (bitangent_y),
        .bitangent_z      (bitangent_z),
        .degenerate       (degenerate),
        .last_of_triangle (last_of_triangle)
    );

endmodule
